/* rtl/cedt_pkg.sv */
// shared types and constants for the contact event dedup table
// no dependencies; imported by every module of the block
package cedt_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int ID_BITS_DEF     = 16;
    localparam int ID_W            = 16;

    typedef logic [ID_W-1:0] id_t;
    typedef logic [1:0]      ctype_t;

    localparam ctype_t CT_RIGID    = 2'd0;
    localparam ctype_t CT_PUSH     = 2'd1;
    localparam ctype_t CT_TRESPASS = 2'd2;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_SWEEP  = 1'b1;

    typedef enum logic [1:0] {
        KIND_EVENT  = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_REJECT = 2'd2,
        KIND_DROP   = 2'd3
    } kind_t;

    typedef struct packed {
        logic   command;
        id_t    entity_one;
        id_t    entity_two;
        ctype_t contact_type;
    } cmd_word_t;

    typedef struct packed {
        kind_t  kind;
        id_t    first_entity;
        id_t    second_entity;
        ctype_t event_type;
        logic   last;
    } res_word_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SWEEP,
        S_RECORD,
        S_INSERT,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic  load;
        logic  walk_start;
        logic  walk_adv;
        logic  scan;
        logic  hit_wr;
        logic  swp_wr;
        logic  ins_wr;
        logic  push;
        kind_t push_kind;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cmd_sweep;
        logic bad_pair;
        logic slot_used;
        logic hit;
        logic emit;
        logic chk_last;
        logic free_found;
        logic out_free;
    } dp_stat_t;

endpackage

/* rtl/contact_event_dedup_table_top.sv */
// contact event dedup table: a record walks the slot memory at one slot per cycle,
// ending early on a hit and skipping the walk for a rejected pair; a sweep walks
// every slot, and any result word waits while the output
// register is full and not taken. one word is handled at a time.
// reset clears the valid bits at once; no clearing pass, ready right after reset.
module contact_event_dedup_table_top
    import cedt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_word_t cmd_word,
    output logic      res_valid,
    input  logic      res_ready,
    output res_word_t res_word
);

    ctrl_cmd_t ctrl;
    dp_stat_t  stat;

    cedt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    cedt_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_word  (cmd_word),
        .ctrl      (ctrl),
        .stat      (stat),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_word  (res_word)
    );

endmodule

/* rtl/cedt_ctrl.sv */
// sequencing state machine for the contact event dedup table
// depends on cedt_pkg; drives cedt_dpath through ctrl_cmd_t
module cedt_ctrl
    import cedt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_ready      = 1'b0;
        ctrl           = '0;
        ctrl.push_kind = KIND_EVENT;
        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.cmd_sweep)
                begin
                    ctrl.walk_start = 1'b1;
                    state_next      = S_SWEEP;
                end
                else if (stat.bad_pair)
                begin
                    if (stat.out_free)
                    begin
                        ctrl.push      = 1'b1;
                        ctrl.push_kind = KIND_REJECT;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    ctrl.walk_start = 1'b1;
                    state_next      = S_RECORD;
                end
            end
            S_SWEEP:
            begin
                // hold the walk while an event word cannot be placed
                if (!(stat.emit && !stat.out_free))
                begin
                    ctrl.swp_wr    = stat.slot_used;
                    ctrl.push      = stat.emit;
                    ctrl.push_kind = KIND_EVENT;
                    if (stat.chk_last)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ctrl.walk_adv = 1'b1;
                    end
                end
            end
            S_RECORD:
            begin
                if (stat.hit)
                begin
                    ctrl.hit_wr = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ctrl.scan = 1'b1;
                    if (stat.chk_last)
                    begin
                        state_next = S_INSERT;
                    end
                    else
                    begin
                        ctrl.walk_adv = 1'b1;
                    end
                end
            end
            S_INSERT:
            begin
                if (stat.free_found)
                begin
                    ctrl.ins_wr = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (stat.out_free)
                begin
                    ctrl.push      = 1'b1;
                    ctrl.push_kind = KIND_DROP;
                    state_next     = S_IDLE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    ctrl.push      = 1'b1;
                    ctrl.push_kind = KIND_DONE;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/cedt_dpath.sv */
// datapath of the contact event dedup table: command registers, slot memory,
// walk pipeline, free slot tracking and result register; depends on cedt_pkg
module cedt_dpath
    import cedt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_word_t cmd_word,
    input  ctrl_cmd_t ctrl,
    output dp_stat_t  stat,
    output logic      res_valid,
    input  logic      res_ready,
    output res_word_t res_word
);

    localparam int IDX_W    = $clog2(TABLE_DEPTH);
    localparam int KEY_BITS = (ID_BITS < ID_W) ? ID_BITS : ID_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    typedef logic [KEY_BITS-1:0] key_t;

    typedef struct packed {
        key_t       first;
        key_t       second;
        ctype_t     ctype;
        logic       sent;
        logic [1:0] age;
    } entry_t;

    // command registers
    logic   sweep_reg;
    key_t   hi_reg;
    key_t   lo_reg;
    ctype_t type_reg;

    // walk pipeline
    logic [IDX_W-1:0] rd_idx_reg;
    logic [IDX_W-1:0] chk_idx_reg;
    entry_t           rd_data_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;

    entry_t mem [TABLE_DEPTH];

    logic      res_valid_reg;
    res_word_t res_word_reg;

    key_t             in_a;
    key_t             in_b;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             out_free;
    logic             slot_used;
    res_word_t        push_word;

    assign in_a = cmd_word.entity_one[KEY_BITS-1:0];
    assign in_b = cmd_word.entity_two[KEY_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            sweep_reg <= (cmd_word.command == CMD_SWEEP);
            hi_reg    <= (in_a > in_b) ? in_a : in_b;
            lo_reg    <= (in_a > in_b) ? in_b : in_a;
            type_reg  <= cmd_word.contact_type;
        end
    end

    // the walk start reads slot 0 directly into the check stage
    assign rd_addr = ctrl.walk_start ? '0 : rd_idx_reg;
    assign rd_en   = ctrl.walk_start || ctrl.walk_adv;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            chk_idx_reg <= rd_addr;
            rd_idx_reg  <= (rd_addr == LAST_IDX) ? rd_addr : rd_addr + 1'b1;
        end
    end

    assign slot_used = valid_reg[chk_idx_reg];

    // write-back for the three update kinds
    always_comb
    begin
        wr_en   = ctrl.hit_wr || ctrl.swp_wr || ctrl.ins_wr;
        wr_addr = chk_idx_reg;
        wr_data = rd_data_reg;
        if (ctrl.ins_wr)
        begin
            wr_addr        = free_idx_reg;
            wr_data.first  = hi_reg;
            wr_data.second = lo_reg;
            wr_data.ctype  = type_reg;
            wr_data.sent   = 1'b0;
            wr_data.age    = 2'd0;
        end
        else if (ctrl.hit_wr)
        begin
            wr_data.sent = (rd_data_reg.age > 2'd1) ? 1'b0 : rd_data_reg.sent;
            wr_data.age  = 2'd0;
        end
        else
        begin
            wr_data.sent = 1'b1;
            wr_data.age  = (rd_data_reg.age == 2'd0) ? 2'd1 : rd_data_reg.age;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
        end
        else
        begin
            if (ctrl.ins_wr)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            else if (ctrl.swp_wr && rd_data_reg.age != 2'd0)
            begin
                valid_reg[chk_idx_reg] <= 1'b0;
            end
            if (ctrl.walk_start)
            begin
                free_found_reg <= 1'b0;
            end
            else if (ctrl.scan && !slot_used && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= chk_idx_reg;
            end
        end
    end

    // result register
    assign out_free = !res_valid_reg || res_ready;

    always_comb
    begin
        push_word.kind          = ctrl.push_kind;
        push_word.first_entity  = id_t'(hi_reg);
        push_word.second_entity = id_t'(lo_reg);
        push_word.event_type    = type_reg;
        push_word.last          = 1'b1;
        case (ctrl.push_kind)
            KIND_EVENT:
            begin
                push_word.first_entity  = id_t'(rd_data_reg.first);
                push_word.second_entity = id_t'(rd_data_reg.second);
                push_word.event_type    = rd_data_reg.ctype;
                push_word.last          = 1'b0;
            end
            KIND_DONE:
            begin
                push_word.first_entity  = '0;
                push_word.second_entity = '0;
                push_word.event_type    = CT_RIGID;
            end
            default:
            begin
                push_word.last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (ctrl.push)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            res_word_reg <= push_word;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    always_comb
    begin
        stat.cmd_sweep  = sweep_reg;
        // equal ids, unused type code, or push/trespass with a null entity
        stat.bad_pair   = (hi_reg == lo_reg) || (type_reg > CT_TRESPASS)
                          || ((type_reg == CT_PUSH || type_reg == CT_TRESPASS)
                              && lo_reg == '0);
        stat.slot_used  = slot_used;
        stat.hit        = slot_used && rd_data_reg.first == hi_reg
                          && rd_data_reg.second == lo_reg;
        stat.emit       = slot_used && !rd_data_reg.sent;
        stat.chk_last   = (chk_idx_reg == LAST_IDX);
        stat.free_found = free_found_reg;
        stat.out_free   = out_free;
    end

endmodule
